// ===== src/i2seg_pkg.sv =====
// Shared types, constants and segment table for the seven-segment command generator.
package i2seg_pkg;

  localparam int VALUE_W = 16;
  localparam int CFG_W = 3;
  localparam int SEG_W = 8;
  localparam int ADDR_W = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] CLAMP_DIGITS = 3'd6;
  localparam logic [CFG_W-1:0] CLAMP_POINT = 3'd5;
  localparam logic [CFG_W-1:0] RESET_DIGIT_COUNT = 3'd6;
  localparam logic [CFG_W-1:0] RESET_POINT_POSITION = 3'd2;

  localparam logic REG_DIGIT_COUNT = 1'b0;
  localparam logic REG_POINT_POSITION = 1'b1;

  localparam logic [SEG_W-1:0] POINT_BIT = 8'h80;
  localparam logic [SEG_W-1:0] MINUS_PATTERN = 8'h01;
  localparam logic [SEG_W-1:0] BLANK_PATTERN = 8'h00;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam logic [VALUE_W-1:0] RECIP_TEN = 16'd52429;
  localparam int RECIP_SHIFT = 19;

  typedef struct packed {
    logic neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

  typedef struct packed {
    logic [CFG_W-1:0] digit_count;
    logic [CFG_W-1:0] point_position;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  function automatic logic [SEG_W-1:0] seg_lookup(input logic [3:0] digit);
    logic [SEG_W-1:0] seg;
    unique case (digit)
      4'd0: seg = 8'h7e;
      4'd1: seg = 8'h30;
      4'd2: seg = 8'h6d;
      4'd3: seg = 8'h79;
      4'd4: seg = 8'h33;
      4'd5: seg = 8'h5b;
      4'd6: seg = 8'h5f;
      4'd7: seg = 8'h70;
      4'd8: seg = 8'h7f;
      4'd9: seg = 8'h7b;
      default: seg = BLANK_PATTERN;
    endcase
    return seg;
  endfunction

endpackage

// ===== src/i2seg_front.sv =====
// Front end: value intake with sign/magnitude split, and the clamped configuration registers.
module i2seg_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [i2seg_pkg::VALUE_W-1:0]    value,
  input  logic                             queue_full,
  input  logic                             write_enable,
  input  logic                             write_index,
  input  logic [i2seg_pkg::CFG_W-1:0]      write_data,
  output logic                             busy,
  output logic                             push,
  output i2seg_pkg::item_t                 push_item,
  output i2seg_pkg::cfg_t                  cfg
);

  logic [i2seg_pkg::CFG_W-1:0] digit_count;
  logic [i2seg_pkg::CFG_W-1:0] point_position;

  assign busy = queue_full;
  assign push = start && !queue_full;

  // -32768 negates to 32768, which still fits the unsigned 16-bit magnitude
  always_comb begin
    push_item.neg = value[i2seg_pkg::VALUE_W-1];
    push_item.mag = value[i2seg_pkg::VALUE_W-1] ? (~value + 16'd1) : value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= i2seg_pkg::RESET_DIGIT_COUNT;
      point_position <= i2seg_pkg::RESET_POINT_POSITION;
    end else if (write_enable) begin
      unique case (write_index)
        i2seg_pkg::REG_DIGIT_COUNT: begin
          digit_count <= (write_data > i2seg_pkg::CLAMP_DIGITS) ?
                         i2seg_pkg::CLAMP_DIGITS : write_data;
        end
        i2seg_pkg::REG_POINT_POSITION: begin
          point_position <= (write_data > i2seg_pkg::CLAMP_POINT) ?
                            i2seg_pkg::CLAMP_POINT : write_data;
        end
        default: ;
      endcase
    end
  end

  assign cfg.digit_count = digit_count;
  assign cfg.point_position = point_position;

endmodule

// ===== src/i2seg_queue.sv =====
// Short queue of classified values between front and back end.
module i2seg_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  i2seg_pkg::item_t  push_item,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output i2seg_pkg::item_t  head
);

  localparam int PTR_W = $clog2(i2seg_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(i2seg_pkg::QUEUE_DEPTH + 1);

  i2seg_pkg::item_t       slots [i2seg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]       wptr;
  logic [PTR_W-1:0]       rptr;
  logic [CNT_W-1:0]       count;

  assign full = (count == CNT_W'(i2seg_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= (wptr == PTR_W'(i2seg_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= (rptr == PTR_W'(i2seg_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      unique case ({push && !full, pop && !empty})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/i2seg_back.sv =====
// Back end: walks display positions, one digit-register command per cycle while running.
module i2seg_back #(
  parameter int MAX_POSITIONS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              empty,
  input  i2seg_pkg::item_t                  head,
  input  i2seg_pkg::cfg_t                   cfg,
  output logic                              pop,
  output logic                              strobe,
  output logic [i2seg_pkg::ADDR_W-1:0]      digit_address,
  output logic [i2seg_pkg::SEG_W-1:0]       segments,
  output logic                              last
);

  localparam int PW = $clog2(MAX_POSITIONS + 1);
  localparam int PROD_W = 2 * i2seg_pkg::VALUE_W;

  i2seg_pkg::state_t state, state_next;

  logic [PW-1:0]                    pos, pos_next;
  logic [i2seg_pkg::VALUE_W-1:0]    mag, mag_next;
  logic                             neg;
  logic                             minus_done, minus_done_next;

  logic [PROD_W-1:0]                prod;
  logic [i2seg_pkg::VALUE_W-1:0]    quot;
  logic [3:0]                       digit;
  logic [PW-1:0]                    point_w, count_w;

  logic [i2seg_pkg::SEG_W-1:0]      cmd_seg;
  logic                             cmd_last;
  logic                             emit;

  assign point_w = PW'(cfg.point_position);
  assign count_w = PW'(cfg.digit_count);

  assign prod = PROD_W'(mag) * PROD_W'(i2seg_pkg::RECIP_TEN);
  assign quot = i2seg_pkg::VALUE_W'(prod >> i2seg_pkg::RECIP_SHIFT);
  assign digit = 4'(mag - i2seg_pkg::VALUE_W'(quot * 16'd10));

  // command selection for the current position
  always_comb begin
    cmd_seg = i2seg_pkg::BLANK_PATTERN;
    mag_next = mag;
    minus_done_next = minus_done;
    pos_next = pos + 1'b1;
    priority if (pos <= point_w) begin
      cmd_seg = i2seg_pkg::seg_lookup(digit) |
                ((pos == point_w) ? i2seg_pkg::POINT_BIT : i2seg_pkg::BLANK_PATTERN);
      mag_next = quot;
    end else if (pos < count_w && mag != '0) begin
      cmd_seg = i2seg_pkg::seg_lookup(digit);
      mag_next = quot;
    end else if (neg && !minus_done && pos < PW'(MAX_POSITIONS)) begin
      cmd_seg = i2seg_pkg::MINUS_PATTERN;
      minus_done_next = 1'b1;
    end else begin
      cmd_seg = i2seg_pkg::BLANK_PATTERN;
    end
    // anything left after this one: point digits, digits or blanks, or a pending minus
    cmd_last = !((pos_next <= point_w) || (pos_next < count_w) ||
                 (neg && !minus_done_next && pos_next < PW'(MAX_POSITIONS)));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      i2seg_pkg::ST_IDLE: if (!empty) state_next = i2seg_pkg::ST_RUN;
      i2seg_pkg::ST_RUN:  if (cmd_last) state_next = i2seg_pkg::ST_IDLE;
      default:            state_next = i2seg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    emit = 1'b0;
    unique case (state)
      i2seg_pkg::ST_IDLE: pop = !empty;
      i2seg_pkg::ST_RUN:  emit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2seg_pkg::ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state <= state_next;
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mag <= head.mag;
      neg <= head.neg;
      pos <= '0;
      minus_done <= 1'b0;
    end else if (emit) begin
      mag <= mag_next;
      pos <= pos_next;
      minus_done <= minus_done_next;
    end
    if (emit) begin
      digit_address <= i2seg_pkg::ADDR_W'(pos) + 1'b1;
      segments <= cmd_seg;
      last <= cmd_last;
    end
  end

endmodule

// ===== src/integer_to_segment_digit_commands_top.sv =====
// Top level of the signed-number to seven-segment digit command generator.
// Usage:
//   Input: a value is transferred at a rising edge with start high and busy low.
//   Output: each digit-register command (digit_address, segments, last) is shown
//   for one cycle with strobe high; last marks the final command of a value.
//   Config: write_enable/write_index/write_data load digit_count (index 0) or
//   point_position (index 1), clamped to 6 and 5; write only while idle.
// Sequencing:
//   The back end walks one display position per cycle, so a value yields 1 to 7
//   commands on consecutive cycles. A transferred value passes through the queue,
//   is loaded by the back end in its idle state, and the run state then registers
//   each command; the back end finishes one value before it loads the next one.
//   The per-cycle step is one 16x16 reciprocal multiply for the divide by ten.
//   A two-entry queue lets the next values be taken while commands go out;
//   busy is high only while that queue is full.
// Reset: rst clears the queue and sequencer, digit_count returns to 6 and
//   point_position to 2. The receiver cannot stall; commands are never held.
module integer_to_segment_digit_commands_top #(
  parameter int MAX_POSITIONS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [15:0]                value,
  output logic                              strobe,
  output logic [3:0]                        digit_address,
  output logic [7:0]                        segments,
  output logic                              last,
  input  logic                              write_enable,
  input  logic                              write_index,
  input  logic [2:0]                        write_data
);

  logic               push;
  logic               pop;
  logic               queue_full;
  logic               queue_empty;
  i2seg_pkg::item_t   push_item;
  i2seg_pkg::item_t   head;
  i2seg_pkg::cfg_t    cfg;

  i2seg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .value        (value),
    .queue_full   (queue_full),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .busy         (busy),
    .push         (push),
    .push_item    (push_item),
    .cfg          (cfg)
  );

  i2seg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (queue_full),
    .empty     (queue_empty),
    .head      (head)
  );

  i2seg_back #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (queue_empty),
    .head          (head),
    .cfg           (cfg),
    .pop           (pop),
    .strobe        (strobe),
    .digit_address (digit_address),
    .segments      (segments),
    .last          (last)
  );

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the signed-number to seven-segment digit command generator.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_POS = 8;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 25;

  localparam logic [i2seg_pkg::SEG_W-1:0] DIGIT_GLYPH [10] = '{
    8'h7e, 8'h30, 8'h6d, 8'h79, 8'h33, 8'h5b, 8'h5f, 8'h70, 8'h7f, 8'h7b
  };

  typedef struct {
    logic [i2seg_pkg::ADDR_W-1:0] addr;
    logic [i2seg_pkg::SEG_W-1:0]  seg;
    logic                         last;
  } cmd_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 start = 1'b0;
  logic signed [i2seg_pkg::VALUE_W-1:0] value = '0;
  logic                                 write_enable = 1'b0;
  logic                                 write_index = 1'b0;
  logic [i2seg_pkg::CFG_W-1:0]          write_data = '0;
  logic                                 busy;
  logic                                 strobe;
  logic [i2seg_pkg::ADDR_W-1:0]         digit_address;
  logic [i2seg_pkg::SEG_W-1:0]          segments;
  logic                                 last;

  cmd_t pending_cmds[$];
  int   shown_digits = i2seg_pkg::RESET_DIGIT_COUNT;
  int   shown_point = i2seg_pkg::RESET_POINT_POSITION;
  int   sender_idle_pct = 0;
  int   mismatch_count = 0;
  int   value_count = 0;
  int   cmd_count = 0;
  int   setting_count = 0;
  int   cycle_count = 0;

  integer_to_segment_digit_commands_top #(.MAX_POSITIONS(MAX_POS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .value(value),
    .strobe(strobe), .digit_address(digit_address), .segments(segments),
    .last(last), .write_enable(write_enable), .write_index(write_index),
    .write_data(write_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d commands still expected", $time, pending_cmds.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic cmd_t make_cmd(input int pos, input logic [i2seg_pkg::SEG_W-1:0] seg);
    cmd_t c;
    c.addr = i2seg_pkg::ADDR_W'(pos + 1);
    c.seg  = seg;
    c.last = 1'b0;
    return c;
  endfunction

  // Digits lowest first, point digit always shown, then minus and blanks.
  function automatic void predict_commands(input logic signed [i2seg_pkg::VALUE_W-1:0] v);
    int   mag;
    int   pos;
    bit   neg;
    cmd_t run[$];
    neg = v < 0;
    mag = neg ? -int'(v) : int'(v);
    for (pos = 0; pos < shown_point; pos++) begin
      run.push_back(make_cmd(pos, DIGIT_GLYPH[mag % 10]));
      mag = mag / 10;
    end
    run.push_back(make_cmd(pos, DIGIT_GLYPH[mag % 10] | i2seg_pkg::POINT_BIT));
    mag = mag / 10;
    pos++;
    while (pos < shown_digits && mag != 0) begin
      run.push_back(make_cmd(pos, DIGIT_GLYPH[mag % 10]));
      mag = mag / 10;
      pos++;
    end
    if (neg && pos < MAX_POS) begin
      run.push_back(make_cmd(pos, i2seg_pkg::MINUS_PATTERN));
      pos++;
    end
    for (; pos < shown_digits; pos++)
      run.push_back(make_cmd(pos, i2seg_pkg::BLANK_PATTERN));
    run[run.size()-1].last = 1'b1;
    foreach (run[k]) pending_cmds.push_back(run[k]);
  endfunction

  always @(posedge clk) begin
    cmd_t want;
    if (!rst && strobe) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected command, expected none, actual addr=%0d seg=%h last=%b",
                 $time, digit_address, segments, last);
        mismatch_count++;
      end else begin
        want = pending_cmds.pop_front();
        cmd_count++;
        if (digit_address !== want.addr) begin
          $display("%0t: digit_address expected %0d actual %0d", $time, want.addr,
                   digit_address);
          mismatch_count++;
        end
        if (segments !== want.seg) begin
          $display("%0t: segments expected %h actual %h (addr %0d)", $time, want.seg,
                   segments, want.addr);
          mismatch_count++;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %b actual %b (addr %0d)", $time, want.last, last,
                   want.addr);
          mismatch_count++;
        end
      end
    end
  end

  // Holds start until the transfer, then maybe leaves a random gap.
  task automatic send_value(input logic signed [i2seg_pkg::VALUE_W-1:0] v);
    int gap;
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    predict_commands(v);
    value_count++;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [i2seg_pkg::CFG_W-1:0] data);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= data;
    @(posedge clk);
    write_enable <= 1'b0;
    if (idx == i2seg_pkg::REG_DIGIT_COUNT)
      shown_digits = data > i2seg_pkg::CLAMP_DIGITS ? i2seg_pkg::CLAMP_DIGITS : data;
    else
      shown_point = data > i2seg_pkg::CLAMP_POINT ? i2seg_pkg::CLAMP_POINT : data;
    @(posedge clk);
  endtask

  task automatic set_display(input logic [i2seg_pkg::CFG_W-1:0] digits,
                             input logic [i2seg_pkg::CFG_W-1:0] point);
    wait_idle();
    write_reg(i2seg_pkg::REG_DIGIT_COUNT, digits);
    write_reg(i2seg_pkg::REG_POINT_POSITION, point);
    setting_count++;
  endtask

  function automatic logic signed [i2seg_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      5, 6:    return i2seg_pkg::VALUE_W'($urandom_range(0, 999));
      7:       return -i2seg_pkg::VALUE_W'($urandom_range(1, 999));
      8: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return i2seg_pkg::VALUE_W'($urandom);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_value(16'sd0);
    send_value(16'sd32767);
    send_value(-16'sd32768);
    send_value(-16'sd1);
    send_value(16'sd5);
  endtask

  // Shortest run is one command, longest is seven.
  task automatic test_run_lengths();
    set_display(3'd0, 3'd0);
    send_value(16'sd7);
    send_value(-16'sd7);
    set_display(3'd6, 3'd5);
    send_value(-16'sd32768);
    send_value(16'sd32767);
  endtask

  task automatic test_clamping();
    set_display(3'd7, 3'd7);
    send_value(-16'sd12345);
    send_value(16'sd999);
  endtask

  task automatic test_point_beyond_count();
    set_display(3'd2, 3'd5);
    send_value(16'sd123);
    send_value(-16'sd45);
    set_display(3'd0, 3'd3);
    send_value(-16'sd9);
  endtask

  // High digits dropped; minus may land past the digit count.
  task automatic test_digit_drop();
    set_display(3'd3, 3'd0);
    send_value(16'sd32767);
    send_value(-16'sd32768);
  endtask

  task automatic test_positive_blanking();
    set_display(3'd5, 3'd1);
    send_value(16'sd42);
    send_value(-16'sd42);
    send_value(16'sd0);
  endtask

  task automatic test_random();
    int idle_by_phase[4] = '{0, 63, 0, 18};
    for (int phase = 0; phase < 4; phase++) begin
      set_display(i2seg_pkg::CFG_W'($urandom_range(0, 7)),
                  i2seg_pkg::CFG_W'($urandom_range(0, 7)));
      sender_idle_pct = idle_by_phase[phase];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_value(pick_value());
    end
    sender_idle_pct = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_run_lengths();
    test_clamping();
    test_point_beyond_count();
    test_digit_drop();
    test_positive_blanking();
    test_random();
    wait_idle();
    $display("Sent %0d values and checked %0d digit commands under %0d display settings,",
             value_count, cmd_count, setting_count);
    $display("including clamped registers, signed extremes and sender gaps.");
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
